FILE: hdl/array_set_table_defines.svh
// assertion macros shared by the array set table rtl
// no dependencies; clk and rst must be in scope where a macro is used
`ifndef ARRAY_SET_TABLE_DEFINES_SVH
`define ARRAY_SET_TABLE_DEFINES_SVH

`ifndef SYNTH

// consequent must hold in the same cycle as the antecedent
`define AST_ASSERT_HOLD(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define AST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define AST_ASSERT_HOLD(lbl, ante, cons, msg)
`define AST_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: hdl/ast_pkg.sv
// types, sizes and codes for the array set table
// no dependencies; used by array_set_table
`timescale 1ns / 1ps

package ast_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int OP_W     = 3;
  localparam int ELEM_W   = 32;
  localparam int COUNT_W  = 7;
  localparam int STATUS_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 3'd0,
    OP_APPEND = 3'd1,
    OP_ADD    = 3'd2,
    OP_REMOVE = 3'd3,
    OP_QUERY  = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY,
    S_SHIFT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic signed [ELEM_W-1:0] element;
  } item_t;

  typedef struct packed {
    logic                found;
    logic [COUNT_W-1:0]  count;
    logic                is_empty;
    logic [STATUS_W-1:0] status;
  } result_t;

endpackage

FILE: hdl/ast_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module ast_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: hdl/array_set_table.sv
// array set table: small unordered set of 32-bit values kept packed in a ram
// depends on ast_pkg, ast_ram and array_set_table_defines.svh
//
//  channel  direction  handshake             payload
//  item     in         item_valid/item_stall   item_t   (operation, element)
//  result   out        result_valid/result_stall result_t (found, count, is_empty, status)
//
// one item at a time: accept, search the entries (stops at the first match),
// apply, then for a remove hit a shift of the entries above the match down
// by one place, then the result.
// search and shift are bound by the single read port of the entry ram, one entry a cycle.
// rst clears the count and control; ram contents are only read below the count.
// a waiting result does not block the next item; a new result waits in its
// final state while the previous one is still stalled.
`timescale 1ns / 1ps
`include "array_set_table_defines.svh"

module array_set_table
  import ast_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  state_t             state, state_next;
  logic [CNT_W-1:0]   elem_count, elem_count_next;
  logic [OP_W-1:0]    op, op_next;
  logic [ELEM_W-1:0]  elem, elem_next;
  logic [CNT_W-1:0]   rd_idx, rd_idx_next;
  logic               pipe_vld, pipe_vld_next;
  logic [IDX_W-1:0]   pipe_idx, pipe_idx_next;
  logic               hit, hit_next;
  logic [IDX_W-1:0]   pos, pos_next;
  status_t            status, status_next;
  logic               result_valid_next;
  result_t            result_next;

  logic               issue;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [ELEM_W-1:0]  wr_data;
  logic [ELEM_W-1:0]  rd_data;

  ast_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_idx[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  assign item_stall = (state != S_IDLE);
  assign issue      = ((state == S_SCAN) || (state == S_SHIFT)) && (rd_idx < elem_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      elem_count   <= '0;
      pipe_vld     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      elem_count   <= elem_count_next;
      pipe_vld     <= pipe_vld_next;
      result_valid <= result_valid_next;
    end
    op       <= op_next;
    elem     <= elem_next;
    rd_idx   <= rd_idx_next;
    pipe_idx <= pipe_idx_next;
    hit      <= hit_next;
    pos      <= pos_next;
    status   <= status_next;
    result   <= result_next;
  end

  always_comb begin
    state_next        = state;
    elem_count_next   = elem_count;
    op_next           = op;
    elem_next         = elem;
    rd_idx_next       = issue ? rd_idx + CNT_W'(1) : rd_idx;
    pipe_vld_next     = issue;
    pipe_idx_next     = rd_idx[IDX_W-1:0];
    hit_next          = hit;
    pos_next          = pos;
    status_next       = status;
    result_valid_next = result_valid && result_stall;
    result_next       = result;
    wr_en             = 1'b0;
    wr_addr           = elem_count[IDX_W-1:0];
    wr_data           = elem;

    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          op_next     = item.operation;
          elem_next   = item.element;
          rd_idx_next = '0;
          hit_next    = 1'b0;
          state_next  = S_SCAN;
        end
      end
      S_SCAN: begin
        // reads are issued ahead of the compare, which uses the registered read data
        if (pipe_vld && (rd_data == elem)) begin
          hit_next   = 1'b1;
          pos_next   = pipe_idx;
          state_next = S_APPLY;
        end else if (!issue && !pipe_vld) begin
          state_next = S_APPLY;
        end
      end
      S_APPLY: begin
        status_next = ST_OK;
        state_next  = S_DONE;
        unique case (op)
          OP_CLEAR: begin
            elem_count_next = '0;
          end
          OP_APPEND, OP_ADD: begin
            if ((op == OP_APPEND) || !hit) begin
              if (elem_count == CNT_W'(CAPACITY)) begin
                status_next = ST_FULL;
              end else begin
                wr_en           = 1'b1;
                elem_count_next = elem_count + CNT_W'(1);
              end
            end
          end
          OP_REMOVE: begin
            if (hit) begin
              rd_idx_next = CNT_W'(pos) + CNT_W'(1);
              state_next  = S_SHIFT;
            end else begin
              status_next = ST_NOT_FOUND;
            end
          end
          default: ;
        endcase
      end
      S_SHIFT: begin
        // entry read at one index lands one place lower
        if (pipe_vld) begin
          wr_en   = 1'b1;
          wr_addr = pipe_idx - IDX_W'(1);
          wr_data = rd_data;
        end
        if (!issue && !pipe_vld) begin
          elem_count_next = elem_count - CNT_W'(1);
          state_next      = S_DONE;
        end
      end
      S_DONE: begin
        if (!result_valid || !result_stall) begin
          result_next.found    = hit;
          result_next.count    = COUNT_W'(elem_count);
          result_next.is_empty = (elem_count == '0);
          result_next.status   = status;
          result_valid_next    = 1'b1;
          state_next           = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  `AST_ASSERT_HOLD(a_count_cap, 1'b1, elem_count <= CNT_W'(CAPACITY), "count beyond capacity")
  `AST_ASSERT_NEXT(a_count_idle, state == S_IDLE, $stable(elem_count), "count moved while idle")
  `AST_ASSERT_HOLD(a_full_count, result_valid && result.status == ST_FULL, result.count == COUNT_W'(CAPACITY), "full status below capacity")
  `AST_ASSERT_HOLD(a_miss_flag, result_valid && result.status == ST_NOT_FOUND, !result.found, "remove miss reports a member")
  `AST_ASSERT_HOLD(a_shift_hit, state == S_SHIFT, hit && (op == OP_REMOVE), "shift without a remove hit")

endmodule
